FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while arst_n is low.
`define GDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that a condition holds in the cycle after a trigger.
`define GDA_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

FILE: src/gda_pkg.sv
package gda_pkg;

	localparam int YEAR_W  = 16;
	localparam int AMT_W   = 16;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	// day + amount, and month + amount, both fit here
	localparam int ACC_W   = 17;

	localparam logic [MONTH_W:0] MONTHS_PER_YEAR = 5'd12;

	// y divisible by 25 iff (y * inverse of 25 mod 2^16) <= 65535 / 25
	localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
	localparam logic [YEAR_W-1:0] DIV25_LIM = 16'd2621;

	// x / 3 == (x * ceil(2^17 / 3)) >> 17 for any x below 2^16
	localparam logic [AMT_W-1:0] INV3    = 16'd43691;
	localparam int               DIV3_SH = 17;
	localparam int               PROD_W  = ACC_W - 2 + AMT_W;

	typedef enum logic [1:0] {
		K_LOAD   = 2'd0,
		K_DAYS   = 2'd1,
		K_MONTHS = 2'd2,
		K_YEARS  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_LEAP_W,
		ST_DIV,
		ST_CARRY,
		ST_YEAR,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		kind_t                kind;
		logic [AMT_W-1:0]     amount;
		logic [YEAR_W-1:0]    load_year;
		logic [MONTH_W-1:0]   load_month;
		logic [DAY_W-1:0]     load_day;
	} req_t;

	typedef struct packed {
		logic [YEAR_W-1:0]    year;
		logic [MONTH_W-1:0]   month;
		logic [DAY_W-1:0]     day;
		logic                 leap;
	} res_t;

	typedef struct packed {
		logic ready;
		logic done;
	} core_ctl_t;

	// months outside 1..12 count as 30 days
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd30;
		endcase
		return len;
	endfunction

endpackage

FILE: src/gda_if.sv
interface gda_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] amount;
	logic [15:0] load_year;
	logic [3:0]  load_month;
	logic [4:0]  load_day;

	modport source (output valid, kind, amount, load_year, load_month, load_day,
		input ready);
	modport sink (input valid, kind, amount, load_year, load_month, load_day,
		output ready);
endinterface

interface gda_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] cur_year;
	logic [3:0]  cur_month;
	logic [4:0]  cur_day;
	logic        leap_flag;

	modport source (output valid, cur_year, cur_month, cur_day, leap_flag, input ready);
	modport sink (input valid, cur_year, cur_month, cur_day, leap_flag, output ready);
endinterface

FILE: src/gda_leap.sv
module gda_leap (
	input  logic [gda_pkg::YEAR_W-1:0] year,
	output logic                       leap
);

	logic [gda_pkg::YEAR_W-1:0] prod;
	logic div4;
	logic div16;
	logic div25;

	assign prod  = year * gda_pkg::INV25;
	assign div25 = (prod <= gda_pkg::DIV25_LIM);
	assign div4  = (year[1:0] == 2'b00);
	assign div16 = (year[3:0] == 4'b0000);

	// /4 and not /100, or /400  ==  /4 and (not /25 or /16)
	assign leap = div4 && (!div25 || div16);

endmodule

FILE: src/gda_core.sv
`include "assert_macros.svh"

module gda_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  gda_pkg::req_t       req,
	input  logic                take,
	output gda_pkg::core_ctl_t  ctl,
	output gda_pkg::res_t       res
);

	gda_pkg::state_t state_q, state_d;

	logic [gda_pkg::YEAR_W-1:0]  year_q;
	logic [gda_pkg::MONTH_W-1:0] month_q;
	logic [gda_pkg::DAY_W-1:0]   day_q;
	logic                        leap_q;

	logic [gda_pkg::ACC_W-1:0]   acc_q;
	logic [gda_pkg::AMT_W-1:0]   addend_q;

	logic                        leap_now;
	logic [gda_pkg::DAY_W-1:0]   mlen;
	logic [gda_pkg::ACC_W-1:0]   sub_a, sub_b;
	logic [gda_pkg::ACC_W:0]     diff;
	logic                        ge, gt;
	logic [gda_pkg::PROD_W-1:0]  q_prod;
	logic [gda_pkg::AMT_W-1:0]   quo_next;
	logic [gda_pkg::ACC_W-1:0]   q_x12;
	logic [gda_pkg::MONTH_W:0]   m_inc;
	logic                        m_wrap;
	logic [gda_pkg::MONTH_W-1:0] m_next;
	logic [gda_pkg::AMT_W-1:0]   addend_sel;
	logic [gda_pkg::YEAR_W:0]    year_sum;
	logic [gda_pkg::YEAR_W-1:0]  year_sat;
	logic [gda_pkg::ACC_W-1:0]   mon_total;
	logic [gda_pkg::ACC_W-1:0]   day_total;
	logic                        mon_carry;

	gda_leap u_leap (
		.year (year_q),
		.leap (leap_now)
	);

	assign mlen = gda_pkg::month_len(month_q, leap_q);

	// shared subtract/compare: month length off the day count, or 12 * carry
	// off the dividend to leave the month
	always_comb begin
		sub_a = acc_q;
		if (state_q == gda_pkg::ST_CARRY) begin
			sub_b = q_x12;
		end else begin
			sub_b = {{(gda_pkg::ACC_W-gda_pkg::DAY_W){1'b0}}, mlen};
		end
	end

	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge   = !diff[gda_pkg::ACC_W];
	assign gt   = ge && (diff[gda_pkg::ACC_W-1:0] != '0);

	// year carry = dividend / 12 = (dividend / 4) / 3 by reciprocal multiply
	assign q_prod   = {{gda_pkg::AMT_W{1'b0}}, acc_q[gda_pkg::ACC_W-1:2]}
	                * {{(gda_pkg::ACC_W-2){1'b0}}, gda_pkg::INV3};
	assign quo_next = gda_pkg::AMT_W'(q_prod >> gda_pkg::DIV3_SH);
	assign q_x12    = {addend_q[gda_pkg::ACC_W-4:0], 3'b000}
	                + {addend_q[gda_pkg::ACC_W-3:0], 2'b00};

	// one month forward; a month up to 15 wraps at most once
	assign m_inc  = {1'b0, month_q} + 5'd1;
	assign m_wrap = (m_inc > gda_pkg::MONTHS_PER_YEAR);
	assign m_next = m_wrap ? gda_pkg::MONTH_W'(m_inc - gda_pkg::MONTHS_PER_YEAR)
	                       : m_inc[gda_pkg::MONTH_W-1:0];

	// saturating year adder
	assign addend_sel = (state_q == gda_pkg::ST_WALK) ? gda_pkg::AMT_W'(1) : addend_q;
	assign year_sum   = {1'b0, year_q} + {1'b0, addend_sel};
	assign year_sat   = year_sum[gda_pkg::YEAR_W] ? '1 : year_sum[gda_pkg::YEAR_W-1:0];

	assign mon_total = {{(gda_pkg::ACC_W-gda_pkg::MONTH_W){1'b0}}, month_q}
	                 + {1'b0, req.amount};
	assign day_total = {{(gda_pkg::ACC_W-gda_pkg::DAY_W){1'b0}}, day_q}
	                 + {1'b0, req.amount};
	assign mon_carry = (mon_total > {{(gda_pkg::ACC_W-gda_pkg::MONTH_W-1){1'b0}},
	                                 gda_pkg::MONTHS_PER_YEAR});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				if (start) begin
					unique case (req.kind)
						gda_pkg::K_LOAD:   state_d = gda_pkg::ST_FIN;
						gda_pkg::K_DAYS:   state_d = gda_pkg::ST_WALK;
						gda_pkg::K_MONTHS: state_d = mon_carry ? gda_pkg::ST_DIV
						                                       : gda_pkg::ST_FIN;
						gda_pkg::K_YEARS:  state_d = gda_pkg::ST_YEAR;
						default:           state_d = gda_pkg::ST_FIN;
					endcase
				end
			end
			gda_pkg::ST_WALK: begin
				if (!gt) begin
					state_d = gda_pkg::ST_FIN;
				end else if (m_wrap) begin
					state_d = gda_pkg::ST_LEAP_W;
				end
			end
			gda_pkg::ST_LEAP_W: state_d = gda_pkg::ST_WALK;
			gda_pkg::ST_DIV:    state_d = gda_pkg::ST_CARRY;
			gda_pkg::ST_CARRY:  state_d = gda_pkg::ST_FIN;
			gda_pkg::ST_YEAR:   state_d = gda_pkg::ST_FIN;
			gda_pkg::ST_FIN:    state_d = gda_pkg::ST_DONE;
			gda_pkg::ST_DONE: begin
				if (take) begin
					state_d = gda_pkg::ST_IDLE;
				end
			end
			default: state_d = gda_pkg::ST_IDLE;
		endcase
	end

	// date state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= gda_pkg::YEAR_W'(1);
			month_q <= gda_pkg::MONTH_W'(1);
			day_q   <= gda_pkg::DAY_W'(1);
			leap_q  <= 1'b0;
		end else begin
			unique case (state_q)
				gda_pkg::ST_IDLE: begin
					if (start && req.kind == gda_pkg::K_LOAD) begin
						year_q  <= req.load_year;
						month_q <= req.load_month;
						day_q   <= req.load_day;
					end else if (start && req.kind == gda_pkg::K_MONTHS && !mon_carry) begin
						month_q <= mon_total[gda_pkg::MONTH_W-1:0];
					end
				end
				gda_pkg::ST_WALK: begin
					if (gt) begin
						month_q <= m_next;
						if (m_wrap) begin
							year_q <= year_sat;
						end
					end else begin
						day_q <= acc_q[gda_pkg::DAY_W-1:0];
					end
				end
				gda_pkg::ST_LEAP_W, gda_pkg::ST_FIN: leap_q <= leap_now;
				gda_pkg::ST_CARRY: begin
					month_q <= diff[gda_pkg::MONTH_W-1:0] + gda_pkg::MONTH_W'(1);
					year_q  <= year_sat;
				end
				gda_pkg::ST_YEAR: year_q <= year_sat;
				default: ;
			endcase
		end
	end

	// working registers, loaded at the start of each beat's work and updated by the walk and the divide
	always_ff @(posedge clk) begin
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				if (start) begin
					// dividend is month + amount - 1; quotient is the year carry
					acc_q    <= (req.kind == gda_pkg::K_DAYS) ? day_total
					                                          : mon_total - gda_pkg::ACC_W'(1);
					addend_q <= req.amount;
				end
			end
			gda_pkg::ST_WALK: begin
				if (gt) begin
					acc_q <= diff[gda_pkg::ACC_W-1:0];
				end
			end
			gda_pkg::ST_DIV: addend_q <= quo_next;
			default: ;
		endcase
	end

	assign ctl.ready = (state_q == gda_pkg::ST_IDLE);
	assign ctl.done  = (state_q == gda_pkg::ST_DONE);

	assign res.year  = year_q;
	assign res.month = month_q;
	assign res.day   = day_q;
	assign res.leap  = leap_q;

	`GDA_ASSERT(a_leap_tracks_year, (state_q != gda_pkg::ST_IDLE) || (leap_q == leap_now), "leap flag out of step with year")
	`GDA_ASSERT(a_rem_below_12, (state_q != gda_pkg::ST_CARRY) || (ge && (diff[gda_pkg::ACC_W-1:0] < gda_pkg::ACC_W'(gda_pkg::MONTHS_PER_YEAR))), "divide remainder reached 12")
	`GDA_ASSERT(a_walk_exit_fits, (state_q != gda_pkg::ST_WALK) || gt || (acc_q[gda_pkg::ACC_W-1:gda_pkg::DAY_W] == '0), "day count too wide at end of walk")
	`GDA_ASSERT_NEXT(a_done_holds, (state_q == gda_pkg::ST_DONE) && !take, state_q == gda_pkg::ST_DONE, "result dropped before it was taken")

endmodule

FILE: src/gregorian_date_adder.sv
// channel  dir  beat payload                                    handshake
// req      in   kind, amount, load_year, load_month, load_day   valid/ready
// rsp      out  cur_year, cur_month, cur_day, leap_flag         valid/ready
//
// One beat in flight at a time; req.ready is high only while the sequencer is idle.
// Load: FIN, DONE. Add years: YEAR, FIN, DONE. Add months: FIN, DONE, or DIV, CARRY, FIN, DONE
// with a year carry (reciprocal divide by 12). Add days: WALK over the months crossed, with
// LEAP_W at each year crossed (leap refresh), then FIN, DONE; the shared subtractor takes one
// month length per cycle outside LEAP_W. Result sits in an output register, so a stalled rsp
// only holds the core once that register is full. arst_n resets the date to 0001-01-01.
module gregorian_date_adder (
	input  logic      clk,
	input  logic      arst_n,
	gda_in_if.sink    req,
	gda_out_if.source rsp
);

	gda_pkg::req_t      req_beat;
	gda_pkg::res_t      res;
	gda_pkg::res_t      res_q;
	gda_pkg::core_ctl_t ctl;
	logic               start;
	logic               take;
	logic               out_valid_q;

	assign req_beat.kind       = gda_pkg::kind_t'(req.kind);
	assign req_beat.amount     = req.amount;
	assign req_beat.load_year  = req.load_year;
	assign req_beat.load_month = req.load_month;
	assign req_beat.load_day   = req.load_day;

	assign req.ready = ctl.ready;
	assign start     = req.valid && ctl.ready;
	assign take      = ctl.done && (!out_valid_q || rsp.ready);

	gda_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req_beat),
		.take   (take),
		.ctl    (ctl),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.cur_year  = res_q.year;
	assign rsp.cur_month = res_q.month;
	assign rsp.cur_day   = res_q.day;
	assign rsp.leap_flag = res_q.leap;

endmodule
